[hw/rtl/b64sd_pkg.sv]
// Shared types, constants and alphabet lookup for the strict Base64 decoder.
package b64sd_pkg;

    // Character codes and alphabet offsets
    localparam logic [7:0] PAD_CHAR       = 8'h3d;
    localparam logic [7:0] UPPER_FIRST    = 8'h41;
    localparam logic [7:0] UPPER_LAST     = 8'h5a;
    localparam logic [7:0] LOWER_FIRST    = 8'h61;
    localparam logic [7:0] LOWER_LAST     = 8'h7a;
    localparam logic [7:0] DIGIT_FIRST    = 8'h30;
    localparam logic [7:0] DIGIT_LAST     = 8'h39;
    localparam logic [7:0] PLUS_CHAR      = 8'h2b;
    localparam logic [7:0] SLASH_CHAR     = 8'h2f;
    localparam logic [5:0] LOWER_BASE     = 6'd26;
    localparam logic [5:0] DIGIT_BASE     = 6'd52;
    localparam logic [5:0] SEXTET_PLUS    = 6'd62;
    localparam logic [5:0] SEXTET_SLASH   = 6'd63;
    localparam logic [5:0] LOW4_MASK      = 6'h0f;
    localparam logic [5:0] LOW2_MASK      = 6'h03;

    // Position within a four-character quantum
    typedef enum logic [1:0] {
        POS_FIRST,
        POS_SECOND,
        POS_THIRD,
        POS_FOURTH
    } qpos_t;

    // Decoder state carried between characters
    typedef struct packed {
        qpos_t      pos;
        logic [5:0] held;
        logic       pad_pending;
        logic       err;
    } dec_state_t;

    // One result as delivered on the output channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        logic       failed;
    } dec_result_t;

    // Map a character to {invalid, six-bit value}
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = {1'b1, 6'd0};
        case (c) inside
            [UPPER_FIRST:UPPER_LAST]: r = {1'b0, 6'(c - UPPER_FIRST)};
            [LOWER_FIRST:LOWER_LAST]: r = {1'b0, 6'(c - LOWER_FIRST) + LOWER_BASE};
            [DIGIT_FIRST:DIGIT_LAST]: r = {1'b0, 6'(c - DIGIT_FIRST) + DIGIT_BASE};
            PLUS_CHAR:                r = {1'b0, SEXTET_PLUS};
            SLASH_CHAR:               r = {1'b0, SEXTET_SLASH};
            default:                  r = {1'b1, 6'd0};
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/b64sd_step.sv]
// Per-character decode step: next decoder state and the result for one character.
module b64sd_step
    import b64sd_pkg::*;
(
    input  logic [7:0]  symbol,
    input  logic        final_req,
    input  dec_state_t  cur,
    output dec_state_t  nxt,
    output dec_result_t res
);

    logic [6:0] lookup;
    logic       sx_ok;
    logic [5:0] sx;
    logic       is_pad;
    logic       emit;
    logic       err;
    logic       pad_set;
    logic       load_first;
    logic [7:0] byte_val;

    assign lookup = sextet_of(symbol);
    assign sx_ok  = ~lookup[6];
    assign sx     = lookup[5:0];
    assign is_pad = (symbol == PAD_CHAR);

    // Classify the character against the quantum position
    always_comb
    begin
        emit       = 1'b0;
        err        = 1'b0;
        pad_set    = 1'b0;
        load_first = 1'b0;
        byte_val   = 8'h00;
        if (!cur.err)
        begin
            case (cur.pos)
                POS_FIRST:
                begin
                    if (!sx_ok || final_req)
                        err = 1'b1;
                    else
                        load_first = 1'b1;
                end
                POS_SECOND:
                begin
                    if (!sx_ok || (final_req && ((sx & LOW4_MASK) != 6'd0)))
                        err = 1'b1;
                    else
                    begin
                        emit     = 1'b1;
                        byte_val = {cur.held, sx[5:4]};
                    end
                end
                POS_THIRD:
                begin
                    if (is_pad)
                    begin
                        if (final_req || ((cur.held & LOW4_MASK) != 6'd0))
                            err = 1'b1;
                        else
                            pad_set = 1'b1;
                    end
                    else if (!sx_ok || (final_req && ((sx & LOW2_MASK) != 6'd0)))
                        err = 1'b1;
                    else
                    begin
                        emit     = 1'b1;
                        byte_val = {cur.held[3:0], sx[5:2]};
                    end
                end
                POS_FOURTH:
                begin
                    if (cur.pad_pending)
                    begin
                        if (!is_pad || !final_req)
                            err = 1'b1;
                    end
                    else if (is_pad)
                    begin
                        if (!final_req || ((cur.held & LOW2_MASK) != 6'd0))
                            err = 1'b1;
                    end
                    else if (!sx_ok)
                        err = 1'b1;
                    else
                    begin
                        emit     = 1'b1;
                        byte_val = {cur.held[1:0], sx};
                    end
                end
                default:
                begin
                    err = 1'b0;
                end
            endcase
        end
    end

    // Next state: clear at end of text, latch errors, advance on good characters
    always_comb
    begin
        nxt = cur;
        if (final_req)
            nxt = '0;
        else if (err)
            nxt.err = 1'b1;
        else if (pad_set)
        begin
            nxt.pad_pending = 1'b1;
            nxt.pos         = POS_FOURTH;
        end
        else if (emit || load_first)
        begin
            nxt.held = sx;
            nxt.pos  = qpos_t'(2'(cur.pos + 2'd1));
        end
    end

    // Result fields
    always_comb
    begin
        res.out_byte   = emit ? byte_val : 8'h00;
        res.byte_valid = emit;
        res.done_res   = final_req;
        res.failed     = cur.err | err;
    end

endmodule

[hw/rtl/base64_strict_decoder.sv]
// Strict streaming Base64 decoder: one character in, one result out per request.
// A result is registered in the result register, or in the skid register when the output stalls.
// Throughput: one character per cycle while in_stall is low; decode logic sits between the state
// register and a two-entry output stage (result register plus skid register).
// in_stall rises only when the skid register is full, so it is a register output.
// Reset clears decoder state and both output entries; payload is not reset.
module base64_strict_decoder
    import b64sd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] symbol,
    input  logic       final_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       done_res,
    output logic       failed
);

    dec_state_t  dec_state_reg;
    dec_state_t  dec_state_next;
    dec_result_t step_res;
    dec_result_t out_data_reg;
    dec_result_t out_data_next;
    dec_result_t skid_data_reg;
    dec_result_t skid_data_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    logic        accept;
    logic        out_free;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid & ~skid_valid_reg;
    assign out_free = ~out_valid_reg | ~out_stall;

    b64sd_step u_step (
        .symbol    (symbol),
        .final_req (final_req),
        .cur       (dec_state_reg),
        .nxt       (dec_state_next),
        .res       (step_res)
    );

    // Route each request into the result register or the skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_valid_next = 1'b1;
                out_data_next  = step_res;
            end
            else
                out_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = step_res;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_state_reg  <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                dec_state_reg <= dec_state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_data_reg.out_byte;
    assign byte_valid = out_data_reg.byte_valid;
    assign done_res   = out_data_reg.done_res;
    assign failed     = out_data_reg.failed;

endmodule

[hw/rtl/b64sd_checker.sv]
// Port-level assertions for the strict Base64 decoder, bound to the top level.
module b64sd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] symbol,
    input logic       final_req,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       done_res,
    input logic       failed
);

    // Hold a stalled request at the input
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(symbol) && $stable(final_req))
        else $error("stalled request changed");

    // Hold a stalled result
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(byte_valid) && $stable(done_res) && $stable(failed))
        else $error("stalled result changed");

    // Drive zero on the byte when no byte is carried
    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == 8'h00)
        else $error("byte not zero without byte_valid");

    // Drop bytes once failure is latched
    a_no_byte_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(byte_valid && failed))
        else $error("byte delivered with failure set");

    // Stall input only while a result waits on the output
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

endmodule

bind base64_strict_decoder b64sd_checker u_b64sd_checker (.*);
